### hdl/fwts_pkg.sv
// Shared constants, types and clamp helpers for the fixed-weight ternary sampler.
package fwts_pkg;

  // Sizing
  localparam int MAX_COLS = 2048;
  localparam int MAX_ROWS = 16;

  // Field and register widths
  localparam int LOC_W    = 11;   // location / column_index
  localparam int ROWO_W   = 4;    // row_index on the output
  localparam int COEF_W   = 2;
  localparam int COLS_W   = 12;   // columns register
  localparam int PAIRS_W  = 11;   // pairs_per_row register
  localparam int ROWS_W   = 5;    // rows register
  localparam int CFG_W    = 12;   // config write data
  localparam int CIDX_W   = 2;    // config register index

  // Derived widths
  localparam int ADDR_W   = $clog2(MAX_COLS);
  localparam int ECOL_W   = $clog2(MAX_COLS + 1);
  localparam int EROW_W   = $clog2(MAX_ROWS + 1);
  localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int TGT_W    = PAIRS_W + 1;

  // Occupancy map tags: an entry is taken when its tag equals the live epoch
  localparam int EPOCH_W  = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX   = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_VOID  = '0;

  // Queue and output buffer depths
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = 1;
  localparam int ODEPTH   = 4;
  localparam int OPTR_W   = 2;

  // Stream word layout
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  // Register reset values
  localparam logic [COLS_W-1:0]  COLUMNS_RST = COLS_W'(600);
  localparam logic [PAIRS_W-1:0] PAIRS_RST   = PAIRS_W'(150);
  localparam logic [ROWS_W-1:0]  ROWS_RST    = ROWS_W'(8);

  // Coefficient codes
  localparam logic signed [COEF_W-1:0] COEF_PLUS  = 2'sb01;
  localparam logic signed [COEF_W-1:0] COEF_MINUS = 2'sb11;

  // Register indexes
  typedef enum logic [CIDX_W-1:0] {
    REG_COLUMNS = 2'd0,
    REG_PAIRS   = 2'd1,
    REG_ROWS    = 2'd2
  } reg_idx_t;

  // Effective settings handed from the config block
  typedef struct packed {
    logic [ECOL_W-1:0] eff_cols;
    logic [TGT_W-1:0]  target;     // placements per row
    logic [EROW_W-1:0] eff_rows;
  } cfg_t;

  // One result word
  typedef struct packed {
    logic [ROWO_W-1:0]        row_index;
    logic [LOC_W-1:0]         column_index;
    logic signed [COEF_W-1:0] coefficient;
    logic                     last_of_matrix;
  } res_t;

  function automatic logic [ECOL_W-1:0] eff_cols_f(input logic [COLS_W-1:0] c);
    logic [ECOL_W-1:0] r;
    if (c < COLS_W'(2)) r = ECOL_W'(2);
    else if (32'(c) > MAX_COLS) r = ECOL_W'(MAX_COLS);
    else r = ECOL_W'(c);
    return r;
  endfunction

  function automatic logic [PAIRS_W-1:0] clamp_pairs_f(input logic [PAIRS_W-1:0] p,
                                                       input logic [ECOL_W-1:0] ec);
    logic [ECOL_W-1:0]  lim;
    logic [PAIRS_W-1:0] r;
    lim = ec >> 1;
    if (p == '0) r = PAIRS_W'(1);
    else if (32'(p) > 32'(lim)) r = PAIRS_W'(lim);
    else r = p;
    return r;
  endfunction

  function automatic logic [EROW_W-1:0] eff_rows_f(input logic [ROWS_W-1:0] r);
    logic [EROW_W-1:0] e;
    if (r == '0) e = EROW_W'(1);
    else if (32'(r) > MAX_ROWS) e = EROW_W'(MAX_ROWS);
    else e = EROW_W'(r);
    return e;
  endfunction

endpackage

### hdl/fixed_weight_ternary_sampler_unit.sv
// Top level of the fixed-weight ternary sampler.
//
// Input stream (s_axis): one candidate column per word. Output stream
// (m_axis): one word per placed coefficient, tlast on the final coefficient
// of the final row. Config channel (cfg_*): index 0 columns, 1 pairs_per_row,
// 2 rows; always ready; a write to a known index restarts the matrix.
// Throughput: one candidate per cycle while no sweep or full output buffer holds
// issue, limited by the single read and single write port of the occupancy map;
// while the epoch sits at its top value no candidate is issued behind one still
// being evaluated, since its row may end in a sweep. An accepted word is queued,
// read against the map and buffered on its way to m_axis. A dropped candidate produces no word.
// Occupancy is tracked with an 8-bit epoch tag per column; starting a new row
// or a restart bumps the epoch. After reset, and after every 255th epoch
// change, the map is swept once over all 2048 entries; no candidate is issued
// to the map during it (s_axis fills the 2-word queue, then holds tready low).
// When m_axis stalls, the 4-word output buffer fills and issue stops; the
// input keeps being taken until the queue is full. Reset empties all buffers
// and reloads columns 600, pairs_per_row 150, rows 8.
module fixed_weight_ternary_sampler_unit (
  input  logic                               clk,
  input  logic                               rst,
  // location [10:0], zeros above
  input  logic [fwts_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // row_index [3:0], column_index [14:4], coefficient [16:15], zeros above
  output logic [fwts_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                               m_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fwts_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [fwts_pkg::CFG_W-1:0]         cfg_data
);

  fwts_pkg::cfg_t               cfg;
  logic                         restart;
  logic                         q_valid;
  logic [fwts_pkg::ADDR_W-1:0]  q_loc;
  logic                         q_pop;
  fwts_pkg::res_t               out_word;

  fwts_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .restart   (restart)
  );

  fwts_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_loc   (s_axis_tdata[fwts_pkg::LOC_W-1:0]),
    .q_valid  (q_valid),
    .q_loc    (q_loc),
    .q_pop    (q_pop)
  );

  fwts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .restart   (restart),
    .q_valid   (q_valid),
    .q_loc     (q_loc),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_word  (out_word)
  );

  // Pack the result word
  assign m_axis_tdata = {
    (fwts_pkg::OUT_TDATA_W - fwts_pkg::ROWO_W - fwts_pkg::LOC_W - fwts_pkg::COEF_W)'(0),
    out_word.coefficient,
    out_word.column_index,
    out_word.row_index
  };
  assign m_axis_tlast = out_word.last_of_matrix;

endmodule

### hdl/fwts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fwts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns old data on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/fwts_cfg.sv
// Configuration registers, clamping and restart pulse.
module fwts_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fwts_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [fwts_pkg::CFG_W-1:0]    cfg_data,
  output fwts_pkg::cfg_t                cfg,
  output logic                          restart
);

  logic [fwts_pkg::COLS_W-1:0]  columns;
  logic [fwts_pkg::PAIRS_W-1:0] pairs;
  logic [fwts_pkg::ROWS_W-1:0]  rows;

  logic [fwts_pkg::COLS_W-1:0]  cols_sel;
  logic [fwts_pkg::PAIRS_W-1:0] pairs_sel;
  logic [fwts_pkg::PAIRS_W-1:0] pairs_next;
  logic                         wr_ok;

  assign cfg_ready = 1'b1;

  // Known index only; unknown indexes are dropped without restart
  assign wr_ok = cfg_valid &&
                 (cfg_index == fwts_pkg::REG_COLUMNS ||
                  cfg_index == fwts_pkg::REG_PAIRS ||
                  cfg_index == fwts_pkg::REG_ROWS);
  assign restart = wr_ok;

  // Pair count is clamped against the column count in force after the write
  always_comb begin
    cols_sel  = (cfg_index == fwts_pkg::REG_COLUMNS) ? cfg_data[fwts_pkg::COLS_W-1:0]
                                                     : columns;
    pairs_sel = (cfg_index == fwts_pkg::REG_PAIRS) ? cfg_data[fwts_pkg::PAIRS_W-1:0]
                                                   : pairs;
    pairs_next = fwts_pkg::clamp_pairs_f(pairs_sel, fwts_pkg::eff_cols_f(cols_sel));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= fwts_pkg::COLUMNS_RST;
      pairs   <= fwts_pkg::PAIRS_RST;
      rows    <= fwts_pkg::ROWS_RST;
    end else if (wr_ok) begin
      columns <= cols_sel;
      pairs   <= pairs_next;
      if (cfg_index == fwts_pkg::REG_ROWS) begin
        rows <= cfg_data[fwts_pkg::ROWS_W-1:0];
      end
    end
  end

  // Effective settings
  assign cfg.eff_cols = fwts_pkg::eff_cols_f(columns);
  assign cfg.target   = {pairs, 1'b0};
  assign cfg.eff_rows = fwts_pkg::eff_rows_f(rows);

endmodule

### hdl/fwts_front.sv
// Front end: accepts candidate words, drops out-of-range ones, queues the rest.
module fwts_front (
  input  logic                          clk,
  input  logic                          rst,
  input  fwts_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fwts_pkg::LOC_W-1:0]    in_loc,
  output logic                          q_valid,
  output logic [fwts_pkg::ADDR_W-1:0]   q_loc,
  input  logic                          q_pop
);

  logic [fwts_pkg::ADDR_W-1:0] slot [fwts_pkg::QDEPTH];
  logic [fwts_pkg::QPTR_W-1:0] wr_ptr;
  logic [fwts_pkg::QPTR_W-1:0] rd_ptr;
  logic [fwts_pkg::QPTR_W:0]   count;
  logic                        in_range;
  logic                        push;
  logic                        pop;

  assign in_ready = (32'(count) < fwts_pkg::QDEPTH);

  // Classify: only in-range columns go on to the map
  assign in_range = (32'(in_loc) < 32'(cfg.eff_cols));
  assign push     = in_valid && in_ready && in_range;
  assign pop      = q_pop && q_valid;

  assign q_valid = (count != '0);
  assign q_loc   = slot[rd_ptr];

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (fwts_pkg::QPTR_W+1)'(push) - (fwts_pkg::QPTR_W+1)'(pop);
    end
  end

  // Queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= fwts_pkg::ADDR_W'(in_loc);
    end
  end

endmodule

### hdl/fwts_back.sv
// Back end: epoch-tagged occupancy map, row/parity counters and output buffer.
module fwts_back (
  input  logic                          clk,
  input  logic                          rst,
  input  fwts_pkg::cfg_t                cfg,
  input  logic                          restart,
  input  logic                          q_valid,
  input  logic [fwts_pkg::ADDR_W-1:0]   q_loc,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output fwts_pkg::res_t                out_word
);

  // Map clearing pass
  logic                          clr_active;
  logic [fwts_pkg::ADDR_W-1:0]   clr_addr;
  logic [fwts_pkg::EPOCH_W-1:0]  epoch;
  logic                          fresh;      // epoch change requested at the last edge

  // Evaluate stage
  logic                          r_valid;
  logic [fwts_pkg::ADDR_W-1:0]   r_loc;
  logic                          fwd_valid;
  logic [fwts_pkg::ADDR_W-1:0]   fwd_loc;

  // Row state
  logic [fwts_pkg::ROW_W-1:0]    row;
  logic [fwts_pkg::TGT_W-1:0]    placed;
  logic                          finished;

  // Output buffer
  fwts_pkg::res_t                obuf [fwts_pkg::ODEPTH];
  logic [fwts_pkg::OPTR_W-1:0]   owr;
  logic [fwts_pkg::OPTR_W-1:0]   ord;
  logic [fwts_pkg::OPTR_W:0]     ocount;

  logic [fwts_pkg::EPOCH_W-1:0]  tag;
  logic                          hit;
  logic                          place;
  logic                          row_done;
  logic                          last;
  logic                          new_epoch;
  logic                          take;
  logic                          ram_we;
  logic [fwts_pkg::ADDR_W-1:0]   ram_waddr;
  logic [fwts_pkg::EPOCH_W-1:0]  ram_wdata;
  fwts_pkg::res_t                res;

  // Issue: room in the buffer for everything in flight, no issue while clearing,
  // and none behind an item that may wrap the epoch
  assign q_pop = q_valid && !clr_active &&
                 (32'(ocount) + 32'(r_valid) < fwts_pkg::ODEPTH) &&
                 !(r_valid && (epoch == fwts_pkg::EPOCH_MAX));

  fwts_ram #(
    .WIDTH (fwts_pkg::EPOCH_W),
    .DEPTH (fwts_pkg::MAX_COLS)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (q_loc),
    .rd_data (tag)
  );

  // Occupancy decision; a row that just cleared is empty by definition
  always_comb begin
    hit      = !fresh && ((fwd_valid && (fwd_loc == r_loc)) || (tag == epoch));
    place    = r_valid && !finished && !hit;
    row_done = (32'(placed) + 1 >= 32'(cfg.target));
    last     = place && row_done && (32'(row) + 1 >= 32'(cfg.eff_rows));
    new_epoch = (place && row_done) || restart;

    ram_we    = clr_active || place;
    ram_waddr = clr_active ? clr_addr : r_loc;
    ram_wdata = clr_active ? fwts_pkg::EPOCH_VOID : epoch;

    res.row_index      = fwts_pkg::ROWO_W'(row);
    res.column_index   = fwts_pkg::LOC_W'(r_loc);
    res.coefficient    = placed[0] ? fwts_pkg::COEF_MINUS : fwts_pkg::COEF_PLUS;
    res.last_of_matrix = last;
  end

  // Evaluate stage, epoch and clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid    <= 1'b0;
      fwd_valid  <= 1'b0;
      fresh      <= 1'b0;
      clr_active <= 1'b1;
      clr_addr   <= '0;
      epoch      <= fwts_pkg::EPOCH_FIRST;
    end else begin
      r_valid   <= q_pop;
      fwd_valid <= place;
      fresh     <= new_epoch;
      if (clr_active) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == fwts_pkg::ADDR_W'(fwts_pkg::MAX_COLS - 1)) begin
          clr_active <= 1'b0;
        end
      end
      if (new_epoch && !clr_active) begin
        if (epoch == fwts_pkg::EPOCH_MAX) begin
          clr_active <= 1'b1;
          clr_addr   <= '0;
          epoch      <= fwts_pkg::EPOCH_FIRST;
        end else begin
          epoch <= epoch + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    r_loc   <= q_loc;
    fwd_loc <= r_loc;
  end

  // Row, parity and completion
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row      <= '0;
      placed   <= '0;
      finished <= 1'b0;
    end else if (place) begin
      if (row_done) begin
        placed <= '0;
        if (last) begin
          finished <= 1'b1;
        end else begin
          row <= row + 1'b1;
        end
      end else begin
        placed <= placed + 1'b1;
      end
    end
  end

  // Output buffer
  assign take      = out_valid && out_ready;
  assign out_valid = (ocount != '0);
  assign out_word  = obuf[ord];

  always_ff @(posedge clk) begin
    if (rst) begin
      owr    <= '0;
      ord    <= '0;
      ocount <= '0;
    end else begin
      if (place) begin
        owr <= owr + 1'b1;
      end
      if (take) begin
        ord <= ord + 1'b1;
      end
      ocount <= ocount + (fwts_pkg::OPTR_W+1)'(place) - (fwts_pkg::OPTR_W+1)'(take);
    end
  end

  always_ff @(posedge clk) begin
    if (place) begin
      obuf[owr] <= res;
    end
  end

endmodule

### hdl/fwts_checker.sv
// Port-level checks for the sampler, bound to the top level.
module fwts_checker (
  input logic                               clk,
  input logic                               rst,
  input logic [fwts_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic [fwts_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input logic                               m_axis_tlast,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic                               cfg_valid,
  input logic                               cfg_ready,
  input logic [fwts_pkg::CIDX_W-1:0]        cfg_index,
  input logic [fwts_pkg::CFG_W-1:0]         cfg_data
);

  // A stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word withdrawn under stall");

  // A stalled result word keeps its contents
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result word changed under stall");

  // Coefficient is +1 or -1, padding is zero
  a_coef: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[16:15] == 2'b01 || m_axis_tdata[16:15] == 2'b11) &&
                      (m_axis_tdata[23:17] == 7'd0))
    else $error("bad coefficient or padding");

  // Buffers are empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result offered right after reset");

  // No result word rises too soon after reset
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(rst, 1) && !$past(rst, 2))
    else $error("result word appeared too soon after reset");

endmodule

bind fixed_weight_ternary_sampler_unit fwts_checker u_fwts_checker (.*);

### verif/tb_top.sv
// Self-checking testbench for the fixed-weight ternary sampler unit.
`timescale 1ns / 100ps

module tb_top;
  import fwts_pkg::*;

  localparam int SETTLE_CYCLES  = 2100;   // a full map sweep may hold dropped words
  localparam int HOLD_CYCLES    = 600;    // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS   = 2000;
  localparam int PHASE_CAP      = 300;    // live candidates per random matrix setting
  localparam int MAX_REPORTS    = 40;
  localparam logic [CIDX_W-1:0] REG_SPARE = 2'd3;  // unmapped register index

  logic                   clk;
  logic                   rst;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CIDX_W-1:0]      cfg_index;
  logic [CFG_W-1:0]       cfg_data;

  // Predicted sampler state and register copies
  logic [MAX_COLS-1:0] occupied;
  int                  row_now;
  int                  placed_now;
  bit                  matrix_done;
  logic [COLS_W-1:0]   columns_reg;
  logic [PAIRS_W-1:0]  pairs_reg;
  logic [ROWS_W-1:0]   rows_reg;
  res_t                coef_expected[$];

  // Run statistics and traffic controls
  int errors           = 0;
  int candidates_sent  = 0;
  int ignored_sent     = 0;
  int live_candidates  = 0;
  int coefs_checked    = 0;
  int matrices_done    = 0;
  int reg_writes       = 0;
  int quiet_cycles     = 0;
  bit rx_steady        = 1'b0;
  bit tx_steady        = 1'b0;
  bit hold_off_req     = 1'b0;
  bit sent_since_write = 1'b0;

  fixed_weight_ternary_sampler_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Column count as the block uses it: at least 2, at most MAX_COLS
  function automatic int active_columns();
    if (columns_reg < COLS_W'(2)) return 2;
    if (int'(columns_reg) > MAX_COLS) return MAX_COLS;
    return int'(columns_reg);
  endfunction

  function automatic int active_rows();
    if (rows_reg == '0) return 1;
    if (int'(rows_reg) > MAX_ROWS) return MAX_ROWS;
    return int'(rows_reg);
  endfunction

  function automatic void restart_matrix();
    occupied    = '0;
    row_now     = 0;
    placed_now  = 0;
    matrix_done = 1'b0;
  endfunction

  // Register write: store, clamp the pair count, restart; unmapped index is a no-op
  function automatic void apply_reg_write(input logic [CIDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] value);
    int lim;
    case (idx)
      REG_COLUMNS: columns_reg = value[COLS_W-1:0];
      REG_PAIRS:   pairs_reg   = value[PAIRS_W-1:0];
      REG_ROWS:    rows_reg    = value[ROWS_W-1:0];
      default:     return;
    endcase
    lim = active_columns() / 2;
    if (pairs_reg == '0) pairs_reg = PAIRS_W'(1);
    if (int'(pairs_reg) > lim) pairs_reg = PAIRS_W'(lim);
    restart_matrix();
  endfunction

  // One candidate: returns 1 and the placed coefficient when the column is taken
  function automatic bit place_candidate(input logic [LOC_W-1:0] loc, output res_t coef);
    coef = '0;
    if (matrix_done) return 1'b0;
    if (int'(loc) >= active_columns()) return 1'b0;
    if (occupied[loc]) return 1'b0;
    occupied[loc]     = 1'b1;
    coef.row_index    = ROWO_W'(row_now);
    coef.column_index = loc;
    coef.coefficient  = placed_now[0] ? COEF_MINUS : COEF_PLUS;
    placed_now++;
    if (placed_now >= 2 * int'(pairs_reg)) begin
      occupied   = '0;
      placed_now = 0;
      if (row_now + 1 >= active_rows()) begin
        coef.last_of_matrix = 1'b1;
        matrix_done         = 1'b1;
      end else begin
        row_now++;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic [LOC_W-1:0] pick_free_column();
    int ec;
    int start;
    int c;
    ec    = active_columns();
    start = $urandom_range(0, ec - 1);
    for (int i = 0; i < ec; i++) begin
      c = (start + i) % ec;
      if (!occupied[c]) return LOC_W'(c);
    end
    return LOC_W'(start);
  endfunction

  // Sender gap: mostly none or short, now and then long
  function automatic int pick_gap();
    int pick;
    if (tx_steady) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 150);
  endfunction

  function automatic void flag_mismatch(input string what, input int want_v, input int got_v);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
  endfunction

  // Send one candidate word and record what it should produce
  task automatic send_location(input logic [LOC_W-1:0] loc);
    res_t coef;
    int   gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= IN_TDATA_W'(loc);
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    candidates_sent++;
    sent_since_write = 1'b1;
    if (matrix_done) ignored_sent++;
    else live_candidates++;
    if (place_candidate(loc, coef)) begin
      coef_expected.push_back(coef);
      if (coef.last_of_matrix) matrices_done++;
    end
  endtask

  // Stop offering and wait until every expected word has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (coef_expected.size() != 0) @(posedge clk);
  endtask

  // Register write, only with the block idle
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    drain();
    if (sent_since_write) begin
      repeat (SETTLE_CYCLES) @(posedge clk);
      sent_since_write = 1'b0;
    end
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    apply_reg_write(idx, value);
    reg_writes++;
  endtask

  // Reset settings: in range, out of range, repeated column, field extremes
  task automatic test_defaults_after_reset();
    send_location(LOC_W'(0));
    send_location(LOC_W'(599));
    send_location(LOC_W'(600));
    send_location(LOC_W'(2047));
    send_location(LOC_W'(0));
    send_location(LOC_W'(1024));
  endtask

  // Smallest matrix: column and row counts below range, input after completion,
  // unmapped register write
  task automatic test_tiny_matrix();
    write_reg(REG_COLUMNS, CFG_W'(0));
    write_reg(REG_ROWS, CFG_W'(0));
    send_location(LOC_W'(1));
    send_location(LOC_W'(1));
    send_location(LOC_W'(2));
    send_location(LOC_W'(2047));
    send_location(LOC_W'(0));
    send_location(LOC_W'(0));
    write_reg(REG_SPARE, '1);
    send_location(LOC_W'(1));
    write_reg(REG_COLUMNS, CFG_W'(1));
    send_location(LOC_W'(0));
    send_location(LOC_W'(1));
  endtask

  // Widest matrix: all registers above range, then pair count of zero
  task automatic test_wide_matrix();
    write_reg(REG_COLUMNS, '1);
    write_reg(REG_PAIRS, '1);
    write_reg(REG_ROWS, '1);
    send_location(LOC_W'(2047));
    send_location(LOC_W'(0));
    send_location(LOC_W'(1023));
    write_reg(REG_PAIRS, CFG_W'(0));
    write_reg(REG_ROWS, CFG_W'(2));
    send_location(LOC_W'(5));
    send_location(LOC_W'(6));
    send_location(LOC_W'(6));
    send_location(LOC_W'(2047));
  endtask

  // Output held off while words keep coming, then a full drain before more
  task automatic test_backpressure();
    write_reg(REG_COLUMNS, CFG_W'(2048));
    write_reg(REG_PAIRS, CFG_W'(1024));
    write_reg(REG_ROWS, CFG_W'(16));
    rx_steady    = 1'b0;
    tx_steady    = 1'b1;
    hold_off_req = 1'b1;
    repeat (40) send_location(pick_free_column());
    tx_steady = 1'b0;
    drain();
    repeat (40) send_location(pick_free_column());
  endtask

  // Random matrix settings, mostly well-formed candidates with some noise
  task automatic test_random_matrices(input int target);
    int                start_live;
    int                pick;
    int                phase_live;
    int                cols_v;
    int                pairs_v;
    int                rows_v;
    bit                pairs_first;
    logic [LOC_W-1:0]  loc;
    start_live = live_candidates;
    while (live_candidates - start_live < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) cols_v = $urandom_range(0, 40);
      else if (pick < 95) cols_v = $urandom_range(41, 400);
      else cols_v = $urandom_range(1000, 4095);
      if ($urandom_range(0, 3) != 0)
        pairs_v = $urandom_range(1, (cols_v / 2 > 1) ? cols_v / 2 : 1);
      else
        pairs_v = $urandom_range(0, 4095);
      rows_v = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 20) : $urandom_range(0, 4095);
      pairs_first = $urandom_range(0, 1);

      // order matters: the pair count is clamped against the columns in place
      if (pairs_first && $urandom_range(0, 9) != 0) write_reg(REG_PAIRS, CFG_W'(pairs_v));
      if ($urandom_range(0, 9) != 0) write_reg(REG_COLUMNS, CFG_W'(cols_v));
      if (!pairs_first && $urandom_range(0, 9) != 0) write_reg(REG_PAIRS, CFG_W'(pairs_v));
      if ($urandom_range(0, 9) != 0) write_reg(REG_ROWS, CFG_W'(rows_v));
      if ($urandom_range(0, 9) == 0) write_reg(REG_SPARE, CFG_W'($urandom_range(0, 4095)));

      tx_steady  = ($urandom_range(0, 4) == 0);
      rx_steady  = ($urandom_range(0, 4) == 0);
      phase_live = 0;
      while (!matrix_done && phase_live < PHASE_CAP &&
             live_candidates - start_live < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) loc = pick_free_column();
        else if (pick < 85) loc = LOC_W'($urandom_range(0, active_columns() - 1));
        else loc = LOC_W'($urandom_range(0, 2047));
        send_location(loc);
        phase_live++;
        if ($urandom_range(0, 199) == 0) drain();
      end
      // a few words after completion, which must vanish
      if (matrix_done)
        repeat ($urandom_range(0, 3)) send_location(LOC_W'($urandom_range(0, 2047)));
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // Receiver: random stalls, steady stretches, one long requested hold-off
  initial begin : receiver
    int stall_left;
    int pick;
    m_axis_tready = 1'b0;
    stall_left    = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_steady) begin
        m_axis_tready <= 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          m_axis_tready <= 1'b1;
        end else begin
          stall_left = (pick < 97) ? $urandom_range(0, 3) : $urandom_range(20, 150);
          m_axis_tready <= 1'b0;
        end
      end
    end
  end

  // Compare each output word with the oldest prediction
  always @(posedge clk) begin : check_results
    res_t                     want;
    logic [ROWO_W-1:0]        got_row;
    logic [LOC_W-1:0]         got_col;
    logic signed [COEF_W-1:0] got_coef;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_row  = m_axis_tdata[ROWO_W-1:0];
      got_col  = m_axis_tdata[ROWO_W +: LOC_W];
      got_coef = m_axis_tdata[ROWO_W + LOC_W +: COEF_W];
      if (coef_expected.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t ns: word with nothing expected, actual row %0d column %0d coef %0d",
                   $time, got_row, got_col, got_coef);
      end else begin
        want = coef_expected.pop_front();
        coefs_checked++;
        if (got_row !== want.row_index)
          flag_mismatch("row_index", int'(want.row_index), int'(got_row));
        if (got_col !== want.column_index)
          flag_mismatch("column_index", int'(want.column_index), int'(got_col));
        if (got_coef !== want.coefficient)
          flag_mismatch("coefficient", int'(want.coefficient), int'(got_coef));
        if (m_axis_tlast !== want.last_of_matrix)
          flag_mismatch("last_of_matrix", int'(want.last_of_matrix), int'(m_axis_tlast));
      end
    end
  end

  // Watchdog on cycles with no transfer on any channel
  always @(posedge clk) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles, %0d words still expected",
               $time, quiet_cycles, coef_expected.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Test sequence
  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    columns_reg   = COLUMNS_RST;
    pairs_reg     = PAIRS_RST;
    rows_reg      = ROWS_RST;
    restart_matrix();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_defaults_after_reset();
    test_tiny_matrix();
    test_wide_matrix();
    test_backpressure();
    test_random_matrices(RANDOM_ITEMS);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run: %0d candidate words (%0d after completion), %0d coefficients checked,",
             candidates_sent, ignored_sent, coefs_checked);
    $display("     %0d matrices completed, %0d register writes, %0d errors",
             matrices_done, reg_writes, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
